// ===== sv/opbm_pkg.sv =====
// ----------------------------------------------------------------------------
// opbm_pkg
// shared widths, codes and reset values of the oversampled peak meter
// ----------------------------------------------------------------------------
`default_nettype none

package opbm_pkg;

  // field and register widths
  localparam int CoefW          = 24;           // Q0.24 coefficients
  localparam int LevelW         = 29;           // Q5.24 levels and followers
  localparam int SumW           = LevelW + 1;   // sum of two followers
  localparam int PeakW          = 24;           // held_peak port
  localparam int VW             = 25;           // magnitude in Q1.24, at most 1.0
  localparam int CmdW           = 2;
  localparam int CfgIdxW        = 3;
  localparam int Oversample     = 4;            // samples per input word
  localparam int SampleBitsDef  = 24;

  // command codes
  localparam logic [CmdW-1:0] CmdProcess = 2'd0;
  localparam logic [CmdW-1:0] CmdRead    = 2'd1;
  localparam logic [CmdW-1:0] CmdClear   = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMode        = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAttackSlow  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAttackFast  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDecayFactor = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLevelGain   = 3'd4;

  // register reset values
  localparam logic [CoefW-1:0] ResetAttackSlow  = 24'd349525;
  localparam logic [CoefW-1:0] ResetAttackFast  = 24'd1502959;
  localparam logic [CoefW-1:0] ResetDecayFactor = 24'd16776604;
  localparam logic [CoefW-1:0] ResetLevelGain   = 24'd8422162;

  // follower ceiling of 20.0 and level saturation
  localparam logic [LevelW-1:0] FollowMax = LevelW'(20 * (2 ** CoefW));
  localparam logic [LevelW-1:0] LevelMax  = '1;

endpackage

`default_nettype wire

// ===== sv/opbm_serial_mul.sv =====
// ----------------------------------------------------------------------------
// opbm_serial_mul
// bit-serial shift-add multiplier giving (coef * x) >> 24
// ----------------------------------------------------------------------------
`default_nettype none

module opbm_serial_mul #(
  parameter int XW = opbm_pkg::SumW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [opbm_pkg::CoefW-1:0]  coef,
  input  logic [XW-1:0]               x,
  output logic                        done,
  output logic [XW-1:0]               prod
);
  import opbm_pkg::*;

  localparam int CntW = $clog2(CoefW);

  logic [CoefW-1:0] creg;
  logic [XW-1:0]    xreg;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic [XW:0]      sum;

  // one coefficient bit a cycle, lsb first; the right shift drops the fraction
  assign sum = {1'b0, prod} + (creg[0] ? {1'b0, xreg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(CoefW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      creg <= coef;
      xreg <= x;
      prod <= '0;
    end else if (busy) begin
      prod <= sum[XW:1];
      creg <= {1'b0, creg[CoefW-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== sv/oversampled_peak_ballistics_meter.sv =====
// ----------------------------------------------------------------------------
// oversampled_peak_ballistics_meter
// true-peak meter on 4x oversampled audio with two ballistic followers
// ----------------------------------------------------------------------------
//
//   channel   handshake                    payload
//   -------   --------------------------   -----------------------------------
//   sample    sample_valid / sample_ready  command, sample_a .. sample_d
//   result    result_valid / result_ready  held_level, held_peak
//   config    cfg_we (no back-pressure)    cfg_index, cfg_data
//
// one word is worked on at a time. in a ballistic process word every multiply
// goes through the bit-serial multipliers, one coefficient bit a cycle, and the
// follower updates are chained sample after sample. a max-mode word scans its
// samples in the scan step and then moves to the done step; read, clear and
// unused codes go straight from idle to the done step.
// a finished result sits in the output register; the next word is taken while
// it waits, and the block only stalls on its last step if it is still unread.
// rst is synchronous and brings back the register defaults and empty holds.
//
`default_nettype none

module oversampled_peak_ballistics_meter #(
  parameter int SAMPLE_BITS = opbm_pkg::SampleBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample words
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [opbm_pkg::CmdW-1:0]     command,
  input  logic signed [SAMPLE_BITS-1:0] sample_a,
  input  logic signed [SAMPLE_BITS-1:0] sample_b,
  input  logic signed [SAMPLE_BITS-1:0] sample_c,
  input  logic signed [SAMPLE_BITS-1:0] sample_d,
  // result words
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [opbm_pkg::LevelW-1:0]   held_level,
  output logic [opbm_pkg::PeakW-1:0]    held_peak,
  // register writes
  input  logic                          cfg_we,
  input  logic [opbm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [opbm_pkg::CoefW-1:0]    cfg_data
);
  import opbm_pkg::*;

  // magnitude to Q5.24: left shift for narrow samples, truncating right shift
  // for samples wider than 25 bits
  localparam int ShL  = (SAMPLE_BITS <= VW) ? VW - SAMPLE_BITS : 0;
  localparam int ShR  = (SAMPLE_BITS >  VW) ? SAMPLE_BITS - VW : 0;
  localparam int ExtW = SAMPLE_BITS + ShL;
  localparam int IdxW = $clog2(Oversample);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(Oversample - 1);

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StDecay  = 8'b0000_0010,
    StSample = 8'b0000_0100,
    StAttack = 8'b0000_1000,
    StSum    = 8'b0001_0000,
    StLevel  = 8'b0010_0000,
    StScan   = 8'b0100_0000,
    StDone   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic             mode;
  logic [CoefW-1:0] attack_slow;
  logic [CoefW-1:0] attack_fast;
  logic [CoefW-1:0] decay_factor;
  logic [CoefW-1:0] level_gain;

  // meter state
  logic [LevelW-1:0]      follower_slow;
  logic [LevelW-1:0]      follower_fast;
  logic [LevelW-1:0]      level_hold;
  logic [SAMPLE_BITS-1:0] peak_hold;
  logic                   restart_pending;

  // working registers
  logic [SAMPLE_BITS-1:0] samp [Oversample];  // sample shift line, head at 0
  logic [IdxW-1:0]        idx;
  logic [LevelW-1:0]      z1;                 // slow follower, or running max
  logic [LevelW-1:0]      z2;                 // fast follower
  logic [SAMPLE_BITS-1:0] pk;

  // datapath
  logic                   accept;
  logic                   go_bal;
  logic                   go_max;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] mag;
  logic [ExtW-1:0]        mag_ext;
  logic [LevelW-1:0]      v;
  logic [LevelW-1:0]      diff1;
  logic [LevelW-1:0]      diff2;
  logic [LevelW-1:0]      fs_clamp;
  logic [LevelW-1:0]      ff_clamp;
  logic [LevelW-1:0]      m_next;
  logic [LevelW-1:0]      level;
  logic                   lanes_done;

  // multiplier lanes: lane 1 serves the slow follower and the output gain
  logic              l1_start, l2_start;
  logic [CoefW-1:0]  l1_coef, l2_coef;
  logic [SumW-1:0]   l1_x, l2_x;
  logic              l1_done, l2_done;
  logic [SumW-1:0]   l1_prod, l2_prod;

  assign accept       = sample_valid && sample_ready;
  assign sample_ready = (state == StIdle);
  assign go_bal       = accept && (command == CmdProcess) && !mode;
  assign go_max       = accept && (command == CmdProcess) && mode;
  assign out_free     = !result_valid || result_ready;
  assign lanes_done   = l1_done && l2_done;

  // absolute value of the head sample; the most negative code maps to 2^(n-1)
  assign mag     = samp[0][SAMPLE_BITS-1] ? (~samp[0] + 1'b1) : samp[0];
  assign mag_ext = ExtW'(mag) << ShL;
  assign v       = LevelW'(VW'(mag_ext >> ShR));

  // followers only rise toward a larger sample
  assign diff1    = (v > z1) ? v - z1 : '0;
  assign diff2    = (v > z2) ? v - z2 : '0;
  assign fs_clamp = (follower_slow > FollowMax) ? FollowMax : follower_slow;
  assign ff_clamp = (follower_fast > FollowMax) ? FollowMax : follower_fast;
  assign m_next   = (v > z1) ? v : z1;
  assign level    = l1_prod[SumW-1] ? LevelMax : l1_prod[LevelW-1:0];

  always_comb begin
    l1_start = go_bal || (state == StSample) || (state == StSum);
    l2_start = go_bal || (state == StSample);
    if (go_bal) begin
      l1_coef = decay_factor;
      l1_x    = SumW'(fs_clamp);
      l2_coef = decay_factor;
      l2_x    = SumW'(ff_clamp);
    end else if (state == StSum) begin
      l1_coef = level_gain;
      l1_x    = SumW'(z1) + SumW'(z2);
      l2_coef = attack_fast;
      l2_x    = SumW'(diff2);
    end else begin
      l1_coef = attack_slow;
      l1_x    = SumW'(diff1);
      l2_coef = attack_fast;
      l2_x    = SumW'(diff2);
    end
  end

  opbm_serial_mul #(.XW(SumW)) u_mul_slow (
    .clk   (clk),
    .rst   (rst),
    .start (l1_start),
    .coef  (l1_coef),
    .x     (l1_x),
    .done  (l1_done),
    .prod  (l1_prod)
  );

  opbm_serial_mul #(.XW(SumW)) u_mul_fast (
    .clk   (clk),
    .rst   (rst),
    .start (l2_start),
    .coef  (l2_coef),
    .x     (l2_x),
    .done  (l2_done),
    .prod  (l2_prod)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      StIdle: begin
        if (accept) begin
          if (command == CmdProcess) begin
            state_next = mode ? StScan : StDecay;
          end else begin
            state_next = StDone;
          end
        end
      end
      StDecay:  if (lanes_done) state_next = StSample;
      StSample: state_next = StAttack;
      StAttack: begin
        if (lanes_done) state_next = (idx == IdxLast) ? StSum : StSample;
      end
      StSum:    state_next = StLevel;
      StLevel:  if (l1_done) state_next = StDone;
      StScan:   if (idx == IdxLast) state_next = StDone;
      StDone:   if (out_free) state_next = StIdle;
      default:  state_next = StIdle;
    endcase
  end

  // control and meter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= StIdle;
      mode            <= 1'b0;
      attack_slow     <= ResetAttackSlow;
      attack_fast     <= ResetAttackFast;
      decay_factor    <= ResetDecayFactor;
      level_gain      <= ResetLevelGain;
      follower_slow   <= '0;
      follower_fast   <= '0;
      level_hold      <= '0;
      peak_hold       <= '0;
      restart_pending <= 1'b1;
      result_valid    <= 1'b0;
      idx             <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CfgMode:        mode         <= cfg_data[0];
          CfgAttackSlow:  attack_slow  <= cfg_data;
          CfgAttackFast:  attack_fast  <= cfg_data;
          CfgDecayFactor: decay_factor <= cfg_data;
          CfgLevelGain:   level_gain   <= cfg_data;
          default: ;
        endcase
      end

      // a new word may replace the one taken at this same edge
      if (state == StDone && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        StIdle: begin
          if (accept) begin
            case (command)
              CmdProcess: idx <= '0;
              CmdRead:    restart_pending <= 1'b1;
              CmdClear: begin
                level_hold      <= '0;
                peak_hold       <= '0;
                restart_pending <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        StAttack: if (lanes_done) idx <= idx + 1'b1;
        StSum: begin
          follower_slow <= z1;
          follower_fast <= z2;
        end
        StLevel: begin
          if (l1_done) begin
            // a pending restart takes this word's values as the new holds
            if (restart_pending) begin
              level_hold      <= level;
              peak_hold       <= pk;
              restart_pending <= 1'b0;
            end else begin
              if (level > level_hold) level_hold <= level;
              if (pk > peak_hold)     peak_hold  <= pk;
            end
          end
        end
        StScan: begin
          idx <= idx + 1'b1;
          if (idx == IdxLast) begin
            level_hold      <= m_next;
            restart_pending <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      samp[0] <= sample_a;
      samp[1] <= sample_b;
      samp[2] <= sample_c;
      samp[3] <= sample_d;
    end else if ((state == StAttack && lanes_done) || state == StScan) begin
      for (int i = 0; i < Oversample - 1; i++) begin
        samp[i] <= samp[i+1];
      end
    end

    if (go_bal) pk <= '0;
    else if (state == StSample && mag > pk) pk <= mag;

    if (go_max) begin
      z1 <= restart_pending ? '0 : level_hold;
    end else if (state == StDecay && lanes_done) begin
      z1 <= l1_prod[LevelW-1:0];
      z2 <= l2_prod[LevelW-1:0];
    end else if (state == StAttack && lanes_done) begin
      z1 <= z1 + l1_prod[LevelW-1:0];
      z2 <= z2 + l2_prod[LevelW-1:0];
    end else if (state == StScan) begin
      z1 <= m_next;
    end

    if (state == StDone && out_free) begin
      held_level <= level_hold;
      held_peak  <= PeakW'(peak_hold);
    end
  end

  // checks
  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    l1_done |-> (state == StDecay || state == StAttack || state == StLevel))
    else $error("multiplier finished outside a waiting step");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (state == StDecay || state == StAttack) |-> (l1_done == l2_done))
    else $error("follower lanes out of step");

  a_follow_ceiling: assert property (@(posedge clk) disable iff (rst)
    (follower_slow <= FollowMax) && (follower_fast <= FollowMax))
    else $error("follower above ceiling");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> (state != StIdle))
    else $error("accepted word left no trace");

endmodule

`default_nettype wire

// ===== tb/oversampled_peak_ballistics_meter_test.sv =====
// ----------------------------------------------------------------------------
// oversampled_peak_ballistics_meter_test
// self-checking bench for the oversampled peak meter with ballistics
// ----------------------------------------------------------------------------
//
// sample words are queued by the stimulus process and driven by a clocked
// driver. Each accepted word is run through a bit-accurate predictor of the
// followers and holds, which queues the expected result word. A clocked
// monitor takes result words under random back-pressure and compares them
// field by field. Registers are reprogrammed between phases, only once
// every expected result has come back. The run starts with short directed
// lists and then moves on to random phases with several register settings and
// idle patterns.
//
`timescale 1ns / 1ps
`default_nettype none

module oversampled_peak_ballistics_meter_test;
  import opbm_pkg::*;

  localparam int SampleBits = SampleBitsDef;
  localparam int CycleLimit = 1_500_000;
  localparam int TailCycles = 200;         // longer than one ballistic word
  localparam int PhaseWords = 130;
  localparam int NumPhases  = 10;

  // codes the package leaves unnamed
  localparam logic [CmdW-1:0]    CmdUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare  = 3'd7;

  typedef struct packed {
    logic [CmdW-1:0]       command;
    logic [SampleBits-1:0] sample_a;
    logic [SampleBits-1:0] sample_b;
    logic [SampleBits-1:0] sample_c;
    logic [SampleBits-1:0] sample_d;
  } sample_word_t;

  typedef struct packed {
    logic [LevelW-1:0] held_level;
    logic [PeakW-1:0]  held_peak;
  } held_word_t;

  // ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  logic [CmdW-1:0]       command = CmdProcess;
  logic [SampleBits-1:0] sample_a = '0;
  logic [SampleBits-1:0] sample_b = '0;
  logic [SampleBits-1:0] sample_c = '0;
  logic [SampleBits-1:0] sample_d = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [LevelW-1:0]     held_level;
  logic [PeakW-1:0]      held_peak;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index = CfgMode;
  logic [CoefW-1:0]      cfg_data = '0;

  // bench state
  sample_word_t word_q[$];       // words waiting for the driver
  held_word_t   held_q[$];       // predicted result words, oldest first
  sample_word_t word_on_bus;
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;

  // predictor copy of the registers
  logic             mode_q         = 1'b0;
  logic [CoefW-1:0] attack_slow_q  = ResetAttackSlow;
  logic [CoefW-1:0] attack_fast_q  = ResetAttackFast;
  logic [CoefW-1:0] decay_q        = ResetDecayFactor;
  logic [CoefW-1:0] gain_q         = ResetLevelGain;

  // predictor copy of the meter state
  logic [LevelW-1:0] follow_slow_q = '0;
  logic [LevelW-1:0] follow_fast_q = '0;
  logic [LevelW-1:0] level_hold_q  = '0;
  logic [PeakW-1:0]  peak_hold_q   = '0;
  logic              restart_q     = 1'b1;

  oversampled_peak_ballistics_meter #(
    .SAMPLE_BITS(SampleBits)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .command      (command),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .sample_c     (sample_c),
    .sample_d     (sample_d),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .held_level   (held_level),
    .held_peak    (held_peak),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // two's complement magnitude, the most negative code gives 2^23
  function automatic logic [SampleBits:0] sample_mag(logic [SampleBits-1:0] raw);
    if (raw[SampleBits-1]) begin
      return {1'b0, ~raw} + 1'b1;
    end
    return {1'b0, raw};
  endfunction

  // Q0.24 coefficient times a level, truncated
  function automatic logic [63:0] coef_mul(logic [CoefW-1:0] c, logic [63:0] x);
    return (64'(c) * x) >> CoefW;
  endfunction

  function automatic logic [63:0] follow_clamp(logic [63:0] z);
    return (z > 64'(FollowMax)) ? 64'(FollowMax) : z;
  endfunction

  // advances the meter by one word and returns the result word it gives
  function automatic held_word_t meter_advance(sample_word_t w);
    logic [SampleBits-1:0] smp [Oversample];
    logic [63:0] z1, z2, pk, lvl, mag, v, m;
    held_word_t r;
    smp[0] = w.sample_a;
    smp[1] = w.sample_b;
    smp[2] = w.sample_c;
    smp[3] = w.sample_d;
    case (w.command)
      CmdProcess: begin
        if (mode_q) begin
          // plain maximum, kept in the level hold only
          m = restart_q ? 64'd0 : 64'(level_hold_q);
          for (int i = 0; i < Oversample; i++) begin
            v = 64'(sample_mag(smp[i])) << (25 - SampleBits);
            if (v > m) m = v;
          end
          if (m > 64'(LevelMax)) m = 64'(LevelMax);
          level_hold_q = m[LevelW-1:0];
          restart_q = 1'b0;
        end else begin
          // decay first, then chase every sample in order
          z1 = coef_mul(decay_q, follow_clamp(64'(follow_slow_q)));
          z2 = coef_mul(decay_q, follow_clamp(64'(follow_fast_q)));
          pk = 64'd0;
          for (int i = 0; i < Oversample; i++) begin
            mag = 64'(sample_mag(smp[i]));
            v = mag << (25 - SampleBits);
            if (v > z1) z1 = z1 + coef_mul(attack_slow_q, v - z1);
            if (v > z2) z2 = z2 + coef_mul(attack_fast_q, v - z2);
            if (mag > pk) pk = mag;
          end
          z1 = follow_clamp(z1);
          z2 = follow_clamp(z2);
          follow_slow_q = z1[LevelW-1:0];
          follow_fast_q = z2[LevelW-1:0];
          lvl = coef_mul(gain_q, z1 + z2);
          if (lvl > 64'(LevelMax)) lvl = 64'(LevelMax);
          if (restart_q) begin
            level_hold_q = lvl[LevelW-1:0];
            peak_hold_q = pk[PeakW-1:0];
            restart_q = 1'b0;
          end else begin
            if (lvl > 64'(level_hold_q)) level_hold_q = lvl[LevelW-1:0];
            if (pk > 64'(peak_hold_q)) peak_hold_q = pk[PeakW-1:0];
          end
        end
      end
      CmdRead: begin
        restart_q = 1'b1;
      end
      CmdClear: begin
        level_hold_q = '0;
        peak_hold_q = '0;
        restart_q = 1'b1;
      end
      default: begin
        // unused code leaves everything as it is
      end
    endcase
    r.held_level = level_hold_q;
    r.held_peak = peak_hold_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // driver: presents queued words, predicts each one as it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        held_q.push_back(meter_advance(word_on_bus));
      end
      // the slot is free once nothing is pending or the word was just taken
      if (!sample_valid || sample_ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          word_on_bus = word_q.pop_front();
          sample_valid <= 1'b1;
          command <= word_on_bus.command;
          sample_a <= word_on_bus.sample_a;
          sample_b <= word_on_bus.sample_b;
          sample_c <= word_on_bus.sample_c;
          sample_d <= word_on_bus.sample_d;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure, compares against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void flag_mismatch(string what, longint unsigned want,
                                        longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    held_word_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (held_q.size() == 0) begin
          flag_mismatch("result word with nothing expected", 0, 64'(held_level));
        end else begin
          want = held_q.pop_front();
          if (held_level !== want.held_level) begin
            flag_mismatch("held_level", 64'(want.held_level), 64'(held_level));
          end
          if (held_peak !== want.held_peak) begin
            flag_mismatch("held_peak", 64'(want.held_peak), 64'(held_peak));
          end
        end
      end
      result_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_word(logic [CmdW-1:0] cmd, logic [SampleBits-1:0] a,
                            logic [SampleBits-1:0] b, logic [SampleBits-1:0] c,
                            logic [SampleBits-1:0] d);
    sample_word_t w;
    w.command = cmd;
    w.sample_a = a;
    w.sample_b = b;
    w.sample_c = c;
    w.sample_d = d;
    word_q.push_back(w);
  endtask

  function automatic logic [SampleBits-1:0] random_sample();
    logic [SampleBits-1:0] s;
    int unsigned style;
    style = $urandom_range(9);
    if (style < 5) begin
      s = SampleBits'($urandom());
    end else if (style < 7) begin
      // quiet material, lets the followers decay
      s = SampleBits'(int'($urandom_range(8191)) - 4096);
    end else if (style == 7) begin
      case ($urandom_range(4))
        0: s = 24'h7FFFFF;
        1: s = 24'h800000;
        2: s = 24'h000000;
        3: s = 24'hFFFFFF;
        default: s = 24'h000001;
      endcase
    end else begin
      // near full scale, either sign
      s = 24'h7FF000 + SampleBits'($urandom_range(4095));
      if ($urandom_range(1) != 0) s = -s;
    end
    return s;
  endfunction

  task automatic queue_random_word();
    int unsigned pick;
    logic [CmdW-1:0] cmd;
    pick = $urandom_range(99);
    // mostly process words, with reads and clears splitting the holds
    if (pick < 82) cmd = CmdProcess;
    else if (pick < 91) cmd = CmdRead;
    else if (pick < 97) cmd = CmdClear;
    else cmd = CmdUnused;
    queue_word(cmd, random_sample(), random_sample(), random_sample(), random_sample());
  endtask

  // blocks until the meter has nothing in flight
  task automatic wait_drained();
    while (word_q.size() != 0 || sample_valid || held_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CfgMode:        mode_q = data[0];
      CfgAttackSlow:  attack_slow_q = data;
      CfgAttackFast:  attack_fast_q = data;
      CfgDecayFactor: decay_q = data;
      CfgLevelGain:   gain_q = data;
      default: begin
        // spare indexes are ignored by the meter
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_meter(logic [CoefW-1:0] m, logic [CoefW-1:0] a_slow,
                               logic [CoefW-1:0] a_fast, logic [CoefW-1:0] decay,
                               logic [CoefW-1:0] gain);
    write_reg(CfgMode, m);
    write_reg(CfgAttackSlow, a_slow);
    write_reg(CfgAttackFast, a_fast);
    write_reg(CfgDecayFactor, decay);
    write_reg(CfgLevelGain, gain);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CoefW-1:0] mode_word;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ballistic mode at reset settings: restart after reset, extremes,
    // reads, clears and the unused code
    queue_word(CmdProcess, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    queue_word(CmdProcess, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    queue_word(CmdProcess, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
    queue_word(CmdProcess, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF);
    queue_word(CmdUnused, 24'hA5A5A5, 24'h5A5A5A, 24'hFFFFFF, 24'h000000);
    queue_word(CmdRead, 24'h123456, 24'h654321, 24'h000000, 24'hFFFFFF);
    queue_word(CmdProcess, 24'd100, -24'd100, 24'd50, -24'd50);
    queue_word(CmdProcess, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    queue_word(CmdClear, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    queue_word(CmdProcess, 24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001);
    queue_word(CmdProcess, 24'h400000, 24'hC00000, 24'h200000, 24'h800000);
    queue_word(CmdRead, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    queue_word(CmdRead, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    queue_word(CmdClear, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    queue_word(CmdClear, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    queue_word(CmdProcess, 24'h7FFFFF, 24'h000000, 24'h000000, 24'h800000);
    wait_drained();

    // max mode, carrying the ballistic level hold across the switch
    write_reg(CfgMode, 24'h000001);
    queue_word(CmdProcess, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    queue_word(CmdRead, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    queue_word(CmdProcess, 24'd5, -24'd7, 24'd3, 24'd1);
    queue_word(CmdProcess, 24'h800000, 24'h000000, 24'h7FFFFF, 24'hFFFFFF);
    queue_word(CmdClear, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    queue_word(CmdUnused, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF);
    queue_word(CmdProcess, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    queue_word(CmdRead, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    wait_drained();

    // random phases; the sender always holds off at a phase boundary until
    // every outstanding result word has been read back
    for (int k = 0; k < NumPhases; k++) begin
      mode_word = 24'($urandom()) & ~24'h1;
      case (k)
        0: program_meter('0, ResetAttackSlow, ResetAttackFast, ResetDecayFactor,
                         ResetLevelGain);
        1: program_meter(mode_word, '0, '0, '0, '0);
        2: program_meter(mode_word, '1, '1, '1, '1);
        3: program_meter(mode_word | 24'h1, 24'($urandom()), 24'($urandom()),
                         24'($urandom()), 24'($urandom()));
        4: begin
          program_meter(mode_word, 24'($urandom()), 24'($urandom()),
                        24'($urandom()), 24'($urandom()));
          write_reg(CfgSpare, 24'($urandom()));
        end
        5: program_meter('0, '1, '1, '0, 24'($urandom()));
        6: program_meter(24'h1, 24'($urandom()), 24'($urandom()),
                         24'($urandom()), 24'($urandom()));
        default: program_meter('0, 24'($urandom()), 24'($urandom()),
                               24'hF00000 | 24'($urandom()), 24'($urandom()));
      endcase
      case (k % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
        default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
      endcase
      for (int n = 0; n < PhaseWords; n++) begin
        queue_random_word();
      end
      wait_drained();
    end

    // let any stray result word show up before judging
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && held_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
